### hw/rtl/typed_integer_alu_macros.svh
// Assertion macros for the typed integer ALU.
// Used by the top level; no other dependencies.
`ifndef TYPED_INTEGER_ALU_MACROS_SVH
`define TYPED_INTEGER_ALU_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define TIA_ASSERT_IMP(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) else $error(msg);
// Next-cycle implication, checked during reset as well.
`define TIA_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) (ant) |=> (con)) else $error(msg);
`else
`define TIA_ASSERT_IMP(lbl, ant, con, msg)
`define TIA_ASSERT_NEXT(lbl, ant, con, msg)
`endif
`endif

### hw/rtl/tia_pkg.sv
// Shared types, codes and helper functions of the typed integer ALU.
// No dependencies.
package tia_pkg;

  localparam logic [3:0] TY_U8   = 4'd0;
  localparam logic [3:0] TY_S8   = 4'd1;
  localparam logic [3:0] TY_S16  = 4'd2;
  localparam logic [3:0] TY_U16  = 4'd3;
  localparam logic [3:0] TY_S32  = 4'd4;
  localparam logic [3:0] TY_U32  = 4'd5;
  localparam logic [3:0] TY_S64  = 4'd6;
  localparam logic [3:0] TY_U64  = 4'd7;
  localparam logic [3:0] TY_BOOL = 4'd8;

  localparam logic [4:0] OP_ADD = 5'd0;
  localparam logic [4:0] OP_SUB = 5'd1;
  localparam logic [4:0] OP_MUL = 5'd2;
  localparam logic [4:0] OP_DIV = 5'd3;
  localparam logic [4:0] OP_MOD = 5'd4;
  localparam logic [4:0] OP_AND = 5'd5;
  localparam logic [4:0] OP_OR  = 5'd6;
  localparam logic [4:0] OP_XOR = 5'd7;
  localparam logic [4:0] OP_SHL = 5'd8;
  localparam logic [4:0] OP_SHR = 5'd9;
  localparam logic [4:0] OP_EQ  = 5'd10;
  localparam logic [4:0] OP_NE  = 5'd11;
  localparam logic [4:0] OP_GT  = 5'd12;
  localparam logic [4:0] OP_GE  = 5'd13;
  localparam logic [4:0] OP_LT  = 5'd14;
  localparam logic [4:0] OP_LE  = 5'd15;
  localparam logic [4:0] OP_NOT = 5'd16;
  localparam logic [4:0] OP_NEG = 5'd17;
  localparam logic [4:0] OP_BOR = 5'd18;

  localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;

  // One classified operation as it travels from front to back.
  typedef struct packed {
    logic [4:0]  op;
    logic        err;
    logic        sgn;
    logic [5:0]  sh;
    logic [3:0]  rty;
    logic [63:0] rmsk;
    logic [63:0] a;
    logic [63:0] b;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [63:0] type_mask(input logic [3:0] ty);
    logic [63:0] m;
    case (ty)
      TY_U8, TY_S8:   m = 64'h0000_0000_0000_00FF;
      TY_S16, TY_U16: m = 64'h0000_0000_0000_FFFF;
      TY_S32, TY_U32: m = 64'h0000_0000_FFFF_FFFF;
      TY_S64, TY_U64: m = 64'hFFFF_FFFF_FFFF_FFFF;
      default:        m = 64'h0000_0000_0000_0001;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] shift_mask(input logic [3:0] ty);
    logic [5:0] m;
    case (ty)
      TY_U8, TY_S8:   m = 6'd7;
      TY_S16, TY_U16: m = 6'd15;
      TY_S32, TY_U32: m = 6'd31;
      TY_S64, TY_U64: m = 6'd63;
      default:        m = 6'd0;
    endcase
    return m;
  endfunction

  function automatic logic type_signed(input logic [3:0] ty);
    return (ty == TY_S8) || (ty == TY_S16) || (ty == TY_S32) || (ty == TY_S64);
  endfunction

  function automatic logic [63:0] sext(input logic [63:0] v, input logic [3:0] ty);
    logic [63:0] r;
    case (ty)
      TY_S8:   r = {{56{v[7]}}, v[7:0]};
      TY_S16:  r = {{48{v[15]}}, v[15:0]};
      TY_S32:  r = {{32{v[31]}}, v[31:0]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/typed_integer_alu.sv
// Typed integer ALU top level: front classifier, two-entry queue, back executor.
// Throughput: one transfer per cycle for simple ops while out_stall is low; the back
// unit is held by mul, div or mod until its result enters the output register.
// Reset (rst, synchronous, active high) empties the queue and the output register.
// Depends on tia_pkg, tia_front, tia_queue, tia_back and the macros header.
`include "typed_integer_alu_macros.svh"
module typed_integer_alu (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  op,
  input  logic [3:0]  type_req,
  input  logic [63:0] lhs,
  input  logic [63:0] rhs,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] result,
  output logic [3:0]  result_type,
  output logic        error
);

  tia_pkg::item_t  f_item;
  tia_pkg::item_t  q_head;
  tia_pkg::qstat_t q_stat;
  logic            push;
  logic            pop;

  // The front decodes the transfer combinationally and writes it into the queue.
  tia_front u_front (
    .op       (op),
    .type_req (type_req),
    .lhs      (lhs),
    .rhs      (rhs),
    .item     (f_item)
  );

  // The input side stalls only when both queue entries are occupied, so new
  // transfers keep arriving while the back works on a long operation.
  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  tia_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (f_item),
    .pop       (pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  // The back pops one item at a time and owns the output register.
  tia_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (q_head),
    .q_empty     (q_stat.empty),
    .pop         (pop),
    .result      (result),
    .result_type (result_type),
    .error       (error),
    .out_valid   (out_valid),
    .out_stall   (out_stall)
  );

  // An errored result always carries zero.
  `TIA_ASSERT_IMP(a_err_zero, out_valid && error, result == 64'd0, "error result not zero")
  // A good bool result is a single bit.
  `TIA_ASSERT_IMP(a_bool_bit, out_valid && !error && result_type == tia_pkg::TY_BOOL,
                  result[63:1] == 63'd0, "bool result wider than one bit")
  // The back never pops an empty queue.
  `TIA_ASSERT_IMP(a_pop_nonempty, pop, !q_stat.empty, "pop from empty queue")
  // Reset leaves no result pending.
  `TIA_ASSERT_NEXT(a_rst_idle, rst, !out_valid, "result valid after reset")

endmodule

### hw/rtl/tia_front.sv
// Front part: normalizes operands to the type and classifies the operation.
// Depends on tia_pkg.
module tia_front (
  input  logic [4:0]     op,
  input  logic [3:0]     type_req,
  input  logic [63:0]    lhs,
  input  logic [63:0]    rhs,
  output tia_pkg::item_t item
);

  logic        ty_ok;
  logic        sgn;
  logic [63:0] msk;
  logic [63:0] a;
  logic [63:0] b;
  logic        err;
  logic [3:0]  rty;

  assign ty_ok = type_req <= tia_pkg::TY_BOOL;
  assign sgn   = tia_pkg::type_signed(type_req);
  assign msk   = tia_pkg::type_mask(type_req);
  assign a     = sgn ? tia_pkg::sext(lhs, type_req) : (lhs & msk);
  assign b     = sgn ? tia_pkg::sext(rhs, type_req) : (rhs & msk);

  always_comb begin
    err = 1'b0;
    rty = type_req;
    priority if (!ty_ok) begin
      err = 1'b1;
      rty = tia_pkg::TY_BOOL;
    end else if (type_req == tia_pkg::TY_BOOL &&
                 (op <= tia_pkg::OP_SHR || op == tia_pkg::OP_NEG)) begin
      err = 1'b1;
    end else if (op <= tia_pkg::OP_SHR) begin
      if ((op == tia_pkg::OP_DIV || op == tia_pkg::OP_MOD) && b == 64'd0) begin
        err = 1'b1;
      end
    end else if (op <= tia_pkg::OP_NOT) begin
      rty = tia_pkg::TY_BOOL;
    end else if (op == tia_pkg::OP_NEG) begin
      if (type_req == tia_pkg::TY_U64) begin
        err = 1'b1;
      end else if (type_req == tia_pkg::TY_U8 || type_req == tia_pkg::TY_S8 ||
                   type_req == tia_pkg::TY_U16) begin
        rty = tia_pkg::TY_S32;
      end else if (type_req == tia_pkg::TY_U32) begin
        rty = tia_pkg::TY_S64;
      end
    end else if (op == tia_pkg::OP_BOR && type_req == tia_pkg::TY_BOOL) begin
      err = 1'b0;
    end else begin
      err = 1'b1;
    end
  end

  always_comb begin
    item.op   = op;
    item.err  = err;
    item.sgn  = sgn;
    item.sh   = b[5:0] & tia_pkg::shift_mask(type_req);
    item.rty  = rty;
    item.rmsk = tia_pkg::type_mask(rty);
    item.a    = a;
    item.b    = b;
  end

endmodule

### hw/rtl/tia_queue.sv
// Two-entry queue between the front and back parts.
// Depends on tia_pkg.
module tia_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tia_pkg::item_t   push_item,
  input  logic             pop,
  output tia_pkg::item_t   head,
  output tia_pkg::qstat_t  stat
);

  tia_pkg::item_t mem [2];
  logic [1:0] cnt;
  logic       wp;
  logic       rp;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_item;
    end
  end

  assign head       = mem[rp];
  assign stat.full  = cnt == 2'd2;
  assign stat.empty = cnt == 2'd0;

endmodule

### hw/rtl/tia_back.sv
// Back part: executes operations and holds the output register.
// Multiply uses one shared 32x32 multiplier for all its partial products; divide is radix-2.
// Depends on tia_pkg.
module tia_back (
  input  logic           clk,
  input  logic           rst,
  input  tia_pkg::item_t head,
  input  logic           q_empty,
  output logic           pop,
  output logic [63:0]    result,
  output logic [3:0]     result_type,
  output logic           error,
  output logic           out_valid,
  input  logic           out_stall
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t      state;
  state_t      state_next;
  logic        out_free;
  logic        is_long;
  logic        load;
  logic [63:0] simple_val;
  logic [63:0] simple_res;
  logic [63:0] ka;
  logic [63:0] kb;

  logic [4:0]  wop;
  logic [3:0]  wrty;
  logic [63:0] wrmsk;
  logic [63:0] wa;
  logic [63:0] wb;
  logic        na;
  logic        nb;
  logic [63:0] acc;
  logic [5:0]  cnt;
  logic [63:0] dq;
  logic [63:0] drem;
  logic [63:0] dd;

  logic [31:0] mx;
  logic [31:0] my;
  logic [63:0] prod;
  logic [64:0] trial;
  logic        ge;
  logic [63:0] quo;
  logic [63:0] rem;
  logic [63:0] long_res;

  assign out_free = !out_valid || !out_stall;
  assign is_long  = !head.err && (head.op == tia_pkg::OP_MUL ||
                    head.op == tia_pkg::OP_DIV || head.op == tia_pkg::OP_MOD);
  assign pop      = (state == S_IDLE) && !q_empty && (is_long || out_free);
  assign load     = (pop && !is_long) || (state == S_FIN);

  assign ka = head.sgn ? (head.a ^ tia_pkg::SIGN64) : head.a;
  assign kb = head.sgn ? (head.b ^ tia_pkg::SIGN64) : head.b;

  always_comb begin
    case (head.op)
      tia_pkg::OP_ADD: simple_val = head.a + head.b;
      tia_pkg::OP_SUB: simple_val = head.a - head.b;
      tia_pkg::OP_AND: simple_val = head.a & head.b;
      tia_pkg::OP_OR:  simple_val = head.a | head.b;
      tia_pkg::OP_XOR: simple_val = head.a ^ head.b;
      tia_pkg::OP_SHL: simple_val = head.a << head.sh;
      tia_pkg::OP_SHR: simple_val = head.sgn ? 64'($signed(head.a) >>> head.sh)
                                             : (head.a >> head.sh);
      tia_pkg::OP_EQ:  simple_val = {63'd0, ka == kb};
      tia_pkg::OP_NE:  simple_val = {63'd0, ka != kb};
      tia_pkg::OP_GT:  simple_val = {63'd0, ka > kb};
      tia_pkg::OP_GE:  simple_val = {63'd0, ka >= kb};
      tia_pkg::OP_LT:  simple_val = {63'd0, ka < kb};
      tia_pkg::OP_LE:  simple_val = {63'd0, ka <= kb};
      tia_pkg::OP_NOT: simple_val = {63'd0, head.a == 64'd0};
      tia_pkg::OP_NEG: simple_val = 64'd0 - head.a;
      tia_pkg::OP_BOR: simple_val = head.a | head.b;
      default:         simple_val = 64'd0;
    endcase
    simple_res = head.err ? 64'd0 : (simple_val & head.rmsk);
  end

  // Partial products: low x low, then the two cross terms shifted up by 32.
  always_comb begin
    case (cnt[1:0])
      2'd0:    begin mx = wa[31:0];  my = wb[31:0];  end
      2'd1:    begin mx = wa[31:0];  my = wb[63:32]; end
      default: begin mx = wa[63:32]; my = wb[31:0];  end
    endcase
    prod = {32'd0, mx} * {32'd0, my};
  end

  assign trial = {drem, dq[63]};
  assign ge    = trial >= {1'b0, dd};

  assign quo      = (na != nb) ? (64'd0 - dq) : dq;
  assign rem      = na ? (64'd0 - drem) : drem;
  assign long_res = ((wop == tia_pkg::OP_MUL) ? acc :
                     (wop == tia_pkg::OP_DIV) ? quo : rem) & wrmsk;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (pop && is_long) begin
          state_next = (head.op == tia_pkg::OP_MUL) ? S_MUL : S_DIV;
        end
      end
      S_MUL: begin
        if (cnt[1:0] == 2'd2) begin
          state_next = S_FIN;
        end
      end
      S_DIV: begin
        if (cnt == 6'd63) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_free) begin
        out_valid <= load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && pop && is_long) begin
      wop   <= head.op;
      wrty  <= head.rty;
      wrmsk <= head.rmsk;
      wa    <= head.a;
      wb    <= head.b;
      na    <= head.sgn && head.a[63];
      nb    <= head.sgn && head.b[63];
      cnt   <= 6'd0;
      acc   <= 64'd0;
      dq    <= (head.sgn && head.a[63]) ? (64'd0 - head.a) : head.a;
      dd    <= (head.sgn && head.b[63]) ? (64'd0 - head.b) : head.b;
      drem  <= 64'd0;
    end else if (state == S_MUL) begin
      cnt <= cnt + 6'd1;
      acc <= (cnt[1:0] == 2'd0) ? prod : (acc + {prod[31:0], 32'd0});
    end else if (state == S_DIV) begin
      cnt  <= cnt + 6'd1;
      dq   <= {dq[62:0], ge};
      drem <= ge ? 64'(trial - {1'b0, dd}) : trial[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && load) begin
      if (state == S_FIN) begin
        result      <= long_res;
        result_type <= wrty;
        error       <= 1'b0;
      end else begin
        result      <= simple_res;
        result_type <= head.rty;
        error       <= head.err;
      end
    end
  end

endmodule
